@@ design/mwsm_pkg.sv @@
// Package for the moving window sum/mean unit.
// Shared constants, register indexes and controller/datapath interface types.
// No dependencies.
package mwsm_pkg;

  // Parameter defaults
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths
  localparam int VALUE_W    = 32;
  localparam int CFG_LEN_W  = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE  = 1'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch an input item, restart window on first
    logic rd;         // read the oldest ring entry
    logic upd;        // update sum, fill, ring and pointer
    logic div_step;   // one quotient bit
    logic load_out;   // move result into the output register
  } mwsm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit;       // this item yields a result (valid during upd)
    logic mean;       // mean mode selected
    logic div_last;   // final divider step
    logic out_free;   // output register can take a result
  } mwsm_sts_t;

endpackage

@@ design/mwsm_ram.sv @@
// Generic simple dual-port RAM with registered read.
// One write port, one read port. No dependencies.
module mwsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mwsm_ctrl.sv @@
// Controller state machine for the moving window sum/mean unit.
// Sequences accept, ring read, update, divide and output load.
// Depends on mwsm_pkg.
module mwsm_ctrl import mwsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mwsm_sts_t  sts_i,
  output mwsm_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (!sts_i.emit) begin
          state_d = ST_IDLE;
        end else if (sts_i.mean) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/mwsm_dp.sv @@
// Datapath for the moving window sum/mean unit: config registers, ring,
// running sum, fill count, write pointer, serial divider and output register.
// Depends on mwsm_pkg and mwsm_ram.
module mwsm_dp import mwsm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          first_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_W-1:0]     value_o,
  input  mwsm_cmd_t                     cmd_i,
  output mwsm_sts_t                     sts_o
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_BITS + LEN_W;
  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int RES_W = (SUM_W > VALUE_W) ? SUM_W : VALUE_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  // Configuration registers
  logic [CFG_LEN_W-1:0] win_len_q;
  logic                 mean_q;
  logic                 len_wr;

  assign len_wr = cfg_we_i && (cfg_idx_i == REG_WINDOW_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= CFG_LEN_W'(1);
      mean_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_LEN: win_len_q <= cfg_data_i[CFG_LEN_W-1:0];
        REG_MEAN_MODE:  mean_q    <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // Effective window length, clamped to 1..MAX_WINDOW
  logic [CMP_W-1:0] wl_ext;
  logic [LEN_W-1:0] len;

  assign wl_ext = CMP_W'(win_len_q);

  always_comb begin
    if (wl_ext == '0) begin
      len = LEN_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wl_ext);
    end
  end

  // Latched item
  logic signed [SAMPLE_BITS-1:0] x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
  end

  // Window state
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [LEN_W-1:0]        fill_q, fill_d, fill_inc, ptr_inc;
  logic [PTR_W-1:0]        wptr_q, wptr_d;
  logic                    full;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic signed [SUM_W-1:0] old_ext, x_ext;

  assign full     = fill_q >= len;
  assign fill_inc = fill_q + LEN_W'(1);
  assign fill_d   = full ? len : fill_inc;
  assign old_ext  = full ? SUM_W'(old_smp) : '0;
  assign x_ext    = SUM_W'(x_q);
  assign sum_d    = sum_q - old_ext + x_ext;
  assign ptr_inc  = LEN_W'(wptr_q) + LEN_W'(1);
  assign wptr_d   = (ptr_inc >= len) ? '0 : PTR_W'(ptr_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      wptr_q <= '0;
    end else if (len_wr || (cmd_i.accept && first_i)) begin
      sum_q  <= '0;
      fill_q <= '0;
      wptr_q <= '0;
    end else if (cmd_i.upd) begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      wptr_q <= wptr_d;
    end
  end

  // Delay ring
  mwsm_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.upd),
    .waddr_i(wptr_q),
    .wdata_i(x_q),
    .re_i   (cmd_i.rd),
    .raddr_i(wptr_q),
    .rdata_o(old_smp)
  );

  // Serial restoring divider for the mean, one quotient bit per cycle
  logic [SUM_W-1:0]  dvd_q;
  logic [LEN_W-1:0]  rem_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [LEN_W:0]    trial;
  logic              ge;
  logic [LEN_W:0]    trial_sub;
  logic [SUM_W-1:0]  dvd_n;
  logic signed [SUM_W-1:0] res_q;

  assign trial     = {rem_q, dvd_q[SUM_W-1]};
  assign ge        = trial >= {1'b0, len};
  assign trial_sub = trial - {1'b0, len};
  assign dvd_n     = {dvd_q[SUM_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      dvd_q <= sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
      neg_q <= sum_d[SUM_W-1];
      rem_q <= '0;
      cnt_q <= '0;
      res_q <= sum_d;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_n;
      rem_q <= ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
      cnt_q <= cnt_q + CNT_W'(1);
      if (sts_o.div_last) begin
        res_q <= neg_q ? $signed(-dvd_n) : $signed(dvd_n);
      end
    end
  end

  // Saturate to the output width
  logic signed [RES_W-1:0] res_ext, sat_hi, sat_lo;
  logic signed [VALUE_W-1:0] sat_val;

  assign res_ext = RES_W'(res_q);
  assign sat_hi  = $signed({{(RES_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}});
  assign sat_lo  = $signed({{(RES_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}});

  always_comb begin
    if (res_ext > sat_hi) begin
      sat_val = sat_hi[VALUE_W-1:0];
    end else if (res_ext < sat_lo) begin
      sat_val = sat_lo[VALUE_W-1:0];
    end else begin
      sat_val = res_ext[VALUE_W-1:0];
    end
  end

  // Output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q <= sat_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

  // Status
  assign sts_o.emit     = fill_d >= len;
  assign sts_o.mean     = mean_q;
  assign sts_o.div_last = cnt_q == CNT_W'(SUM_W - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

@@ design/moving_window_sum_mean_unit.sv @@
// Top level of the moving window sum/mean unit (boxcar filter).
// Depends on mwsm_pkg, mwsm_ctrl, mwsm_dp (and mwsm_ram through it).
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------
//  in      | in_valid_i/in_ready_o  | sample_i (24b signed), first_i
//  out     | out_valid_o/out_ready_i| value_o (32b signed)
//  cfg     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// An item passes through accept, the registered ring read and the update;
// one that yields a sum then goes to the hold state to load the output.
// In mean mode the serial divider adds SUM_W steps before the output load
// (SAMPLE_BITS + clog2(MAX_WINDOW+1), 33 at defaults), one quotient bit each.
// The output register lets the next item be taken while a result waits;
// a result that finds the output register occupied holds until it drains.
// Reset is asynchronous and clears control state; no clearing pass is needed.
module moving_window_sum_mean_unit import mwsm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          first_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_W-1:0]     value_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  mwsm_cmd_t cmd;
  mwsm_sts_t sts;

  mwsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mwsm_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_i),
    .first_i    (first_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
